// ===== src/button_click_hold_detector_macros.svh =====
// ---------------------------------------------------------------------------
// Button click and hold detector assertion macros
// Shorthand for clocked assertions with a synchronous active-high reset.
// ---------------------------------------------------------------------------
`ifndef BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_CLICK_HOLD_DETECTOR_MACROS_SVH

// Same-cycle implication.
`define BCHD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bchd assertion failed");

// Next-cycle implication.
`define BCHD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bchd assertion failed");

`endif

// ===== src/bchd_pkg.sv =====
// ---------------------------------------------------------------------------
// Button click and hold detector package
// Field widths, register indexes and register reset values.
// ---------------------------------------------------------------------------
package bchd_pkg;

  localparam int TIME_W      = 32;
  localparam int MS16_W      = 16;
  localparam int COUNT_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_LEVEL       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PRESS_COOLDOWN     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIMEOUT       = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_REPEAT_ENABLE = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_REPEAT_INTVL  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_CLICK_WINDOW       = 3'd5;

  localparam logic [MS16_W-1:0]  RST_PRESS_COOLDOWN = 16'd50;
  localparam logic [MS16_W-1:0]  RST_HOLD_TIMEOUT   = 16'd500;
  localparam logic [MS16_W-1:0]  RST_CLICK_WINDOW   = 16'd300;
  localparam logic [COUNT_W-1:0] COUNT_MAX          = 16'hFFFF;

endpackage

// ===== src/bchd_in_if.sv =====
// ---------------------------------------------------------------------------
// Button click and hold detector sample channel
// Valid/ready channel carrying one timestamped pin sample per word.
// ---------------------------------------------------------------------------
interface bchd_in_if;
  import bchd_pkg::*;

  logic              valid;
  logic              ready;
  logic              sample_level;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output sample_level, output now_ms, input ready);
  modport sink (input valid, input sample_level, input now_ms, output ready);
endinterface

// ===== src/bchd_out_if.sv =====
// ---------------------------------------------------------------------------
// Button click and hold detector event channel
// Valid/ready channel carrying the event flags of one sample per word.
// ---------------------------------------------------------------------------
interface bchd_out_if;
  import bchd_pkg::*;

  logic               valid;
  logic               ready;
  logic               press_fire;
  logic [COUNT_W-1:0] press_clicks;
  logic               hold_fire;
  logic [COUNT_W-1:0] hold_clicks;
  logic               release_fire;

  modport source (output valid, output press_fire, output press_clicks,
                  output hold_fire, output hold_clicks, output release_fire,
                  input ready);
  modport sink (input valid, input press_fire, input press_clicks,
                input hold_fire, input hold_clicks, input release_fire,
                output ready);
endinterface

// ===== src/button_click_hold_detector.sv =====
// ---------------------------------------------------------------------------
// Button click and hold detector
// Detects clicks, multi-click groups, long presses and releases from
// timestamped pin samples.
// ---------------------------------------------------------------------------
//  Channel   Dir  Payload
//  pin       in   sample_level, now_ms
//  result    out  press_fire, press_clicks, hold_fire, hold_clicks, release_fire
//  cfg       in   cfg_we, cfg_index, cfg_data
//
//  One word per clock sustained while the result is not stalled; the
//  detector state updates as a word moves from the input register into
//  the result register.
//  Reset restores the register defaults and clears the detector state.
//  A stalled result holds; one more word waits in the input register.
// ---------------------------------------------------------------------------
module button_click_hold_detector (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bchd_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bchd_pkg::CFG_DATA_W-1:0]  cfg_data,
  bchd_in_if.sink                          pin,
  bchd_out_if.source                       result
);
  import bchd_pkg::*;

  logic               active_level;
  logic [MS16_W-1:0]  press_cooldown_ms;
  logic [MS16_W-1:0]  hold_timeout_ms;
  logic               hold_repeat_enable;
  logic [TIME_W-1:0]  hold_repeat_interval_ms;
  logic [MS16_W-1:0]  click_window_ms;

  logic               prev_level;
  logic               prev_hold;
  logic [TIME_W-1:0]  press_time;
  logic [TIME_W-1:0]  hold_fire_time;
  logic [COUNT_W-1:0] click_count;

  logic               s1_valid;
  logic               s1_level;
  logic [TIME_W-1:0]  s1_now;

  logic               out_valid;
  logic               out_press_fire;
  logic [COUNT_W-1:0] out_press_clicks;
  logic               out_hold_fire;
  logic [COUNT_W-1:0] out_hold_clicks;
  logic               out_release_fire;

  logic               advance;
  logic [TIME_W-1:0]  since_press;
  logic [TIME_W-1:0]  since_hold_fire;
  logic               active;
  logic               was_active;
  logic               hold;
  logic               p_fire;
  logic               h_fire;
  logic               r_fire;
  logic [COUNT_W-1:0] count_mid;
  logic               prev_level_next;
  logic [TIME_W-1:0]  press_time_next;
  logic [TIME_W-1:0]  hold_fire_time_next;
  logic [COUNT_W-1:0] click_count_next;

  assign advance    = s1_valid && (!out_valid || result.ready);
  assign pin.ready  = !s1_valid || advance;

  assign result.valid        = out_valid;
  assign result.press_fire   = out_press_fire;
  assign result.press_clicks = out_press_clicks;
  assign result.hold_fire    = out_hold_fire;
  assign result.hold_clicks  = out_hold_clicks;
  assign result.release_fire = out_release_fire;

  always_comb begin
    since_press     = s1_now - press_time;
    since_hold_fire = s1_now - hold_fire_time;
    active          = (s1_level == active_level);
    was_active      = (prev_level == active_level);
    hold            = active && (since_press > {{(TIME_W-MS16_W){1'b0}}, hold_timeout_ms});

    p_fire    = (click_count != '0) && !active &&
                (since_press > {{(TIME_W-MS16_W){1'b0}}, click_window_ms});
    count_mid = p_fire ? '0 : click_count;

    h_fire              = 1'b0;
    r_fire              = 1'b0;
    prev_level_next     = s1_level;
    press_time_next     = press_time;
    hold_fire_time_next = hold_fire_time;
    click_count_next    = count_mid;

    if (active && !was_active) begin
      if (since_press > {{(TIME_W-MS16_W){1'b0}}, press_cooldown_ms}) begin
        press_time_next = s1_now;
      end else begin
        prev_level_next = ~s1_level;
      end
    end else if (!active && was_active) begin
      r_fire = 1'b1;
      if (!prev_hold && (count_mid != COUNT_MAX)) begin
        click_count_next = count_mid + COUNT_W'(1);
      end
    end else if (hold && (hold_repeat_enable || !prev_hold)) begin
      if ((hold_repeat_interval_ms == '0) || (since_hold_fire > hold_repeat_interval_ms)) begin
        h_fire              = 1'b1;
        hold_fire_time_next = s1_now;
        click_count_next    = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_level            <= 1'b0;
      press_cooldown_ms       <= RST_PRESS_COOLDOWN;
      hold_timeout_ms         <= RST_HOLD_TIMEOUT;
      hold_repeat_enable      <= 1'b0;
      hold_repeat_interval_ms <= '0;
      click_window_ms         <= RST_CLICK_WINDOW;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_LEVEL:       active_level            <= cfg_data[0];
        REG_PRESS_COOLDOWN:     press_cooldown_ms       <= cfg_data[MS16_W-1:0];
        REG_HOLD_TIMEOUT:       hold_timeout_ms         <= cfg_data[MS16_W-1:0];
        REG_HOLD_REPEAT_ENABLE: hold_repeat_enable      <= cfg_data[0];
        REG_HOLD_REPEAT_INTVL:  hold_repeat_interval_ms <= cfg_data[TIME_W-1:0];
        REG_CLICK_WINDOW:       click_window_ms         <= cfg_data[MS16_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid       <= 1'b0;
      out_valid      <= 1'b0;
      prev_level     <= 1'b1;
      prev_hold      <= 1'b0;
      press_time     <= '0;
      hold_fire_time <= '0;
      click_count    <= '0;
    end else begin
      if (pin.valid && pin.ready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        out_valid      <= 1'b1;
        prev_level     <= prev_level_next;
        prev_hold      <= hold;
        press_time     <= press_time_next;
        hold_fire_time <= hold_fire_time_next;
        click_count    <= click_count_next;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pin.valid && pin.ready) begin
      s1_level <= pin.sample_level;
      s1_now   <= pin.now_ms;
    end
    if (advance) begin
      out_press_fire   <= p_fire;
      out_press_clicks <= p_fire ? click_count : '0;
      out_hold_fire    <= h_fire;
      out_hold_clicks  <= h_fire ? count_mid : '0;
      out_release_fire <= r_fire;
    end
  end

endmodule

// ===== src/bchd_port_check.sv =====
// ---------------------------------------------------------------------------
// Button click and hold detector port checks
// Assertions on the result channel, bound to the top level.
// ---------------------------------------------------------------------------
`include "button_click_hold_detector_macros.svh"

module bchd_port_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         press_fire,
  input logic [bchd_pkg::COUNT_W-1:0] press_clicks,
  input logic                         hold_fire,
  input logic                         release_fire
);
  import bchd_pkg::*;

  `BCHD_ASSERT_NOW(a_press_hold_excl, clk, rst, out_valid, !(press_fire && hold_fire))
  `BCHD_ASSERT_NOW(a_hold_release_excl, clk, rst, out_valid, !(hold_fire && release_fire))
  `BCHD_ASSERT_NOW(a_press_count, clk, rst, out_valid, press_fire == (press_clicks != '0))
  `BCHD_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid)

endmodule

bind button_click_hold_detector bchd_port_check u_port_check (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (result.valid),
  .out_ready    (result.ready),
  .press_fire   (result.press_fire),
  .press_clicks (result.press_clicks),
  .hold_fire    (result.hold_fire),
  .release_fire (result.release_fire)
);
